>>> design/ptwa_pkg.sv
`timescale 1ns / 1ps

package ptwa_pkg;

	localparam int ADDR_W   = 48;
	localparam int TIME_W   = 32;
	localparam int TMO_W    = 16;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 4;
	localparam int COUNT_W  = 5;
	localparam int PADDR_W  = 2;
	localparam int PDATA_W  = 32;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd5;

	// register word addresses
	localparam logic [PADDR_W-1:0] REG_TIMEOUT = 2'd0;

	typedef enum logic [OP_W-1:0] {
		OP_LEARN = 2'd0,
		OP_SWEEP = 2'd1,
		OP_LIST  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_REFRESHED = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_FULL      = 3'd2,
		ST_SWEPT     = 3'd3,
		ST_LISTED    = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ADDR_W-1:0] peer_address;
		logic [TIME_W-1:0] now_seconds;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  entry_index;
		logic [ADDR_W-1:0]   listed_address;
		logic [COUNT_W-1:0]  removed_count;
		logic [COUNT_W-1:0]  entry_count;
		logic                last;
	} result_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	// per-cycle command to every cell of the chain
	typedef struct packed {
		logic step;
		logic put;
	} cell_ctl_t;

endpackage

>>> design/ptwa_cell.sv
`timescale 1ns / 1ps

module ptwa_cell #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  ptwa_pkg::cell_ctl_t ctl,
	input  logic [IW-1:0]       put_idx,
	input  ptwa_pkg::entry_t    put_data,
	input  ptwa_pkg::entry_t    next,
	output ptwa_pkg::entry_t    held
);
	import ptwa_pkg::*;

	entry_t entry_q;
	logic   hit;

	assign hit  = ctl.put && (put_idx == IW'(IDX));
	assign held = entry_q;

	// a put aimed at this cell wins over the shift from the neighbour
	always_ff @(posedge clk) begin
		if (hit) begin
			entry_q <= put_data;
		end else if (ctl.step) begin
			entry_q <= next;
		end
	end

endmodule

>>> design/peer_table_with_aging.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      item   (ptwa_pkg::item_t)
// result    out        result_valid / result_ready  result (ptwa_pkg::result_t)
// config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// The table is a chain of cells with the oldest position at cell 0. Learn, sweep and list
// rotate the chain once over the held entries, one entry per cycle through cell 0; a list
// advances only while its results are taken, and a stalled result side holds the item in
// work. A list gives one result per cycle while results are taken. Reset clears the entry
// count and the timeout to 5; the entries themselves are not cleared. One item is in
// work at a time; a finished result waits in the output register while the next item is
// taken.

module peer_table_with_aging #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  ptwa_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output ptwa_pkg::result_t               result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ptwa_pkg::PADDR_W-1:0]    paddr,
	input  logic [ptwa_pkg::PDATA_W-1:0]    pwdata,
	output logic [ptwa_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import ptwa_pkg::*;

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [TIME_W-1:0]  now_q;
	logic [TMO_W-1:0]   timeout_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      k_q;
	logic [CW-1:0]      occ_q;
	logic [CW-1:0]      removed_q;
	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	logic               result_valid_q;
	result_t            result_q;

	entry_t             cells [TABLE_ENTRIES];
	cell_ctl_t          ctl;
	logic [IW-1:0]      put_idx;
	entry_t             put_data;
	entry_t             head;

	logic               slot_free;
	logic               run_done;
	logic               go;
	logic               keep;
	logic               match;
	logic               done;
	logic               emit;
	logic [TIME_W-1:0]  age;
	result_t            rsp_d;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			entry_t nb;
			if (gi < TABLE_ENTRIES - 1) begin : g_mid
				assign nb = cells[gi + 1];
			end else begin : g_end
				assign nb = cells[gi];
			end
			ptwa_cell #(
				.IW  (IW),
				.IDX (gi)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.put_idx  (put_idx),
				.put_data (put_data),
				.next     (nb),
				.held     (cells[gi])
			);
		end
	endgenerate

	assign head         = cells[0];
	assign slot_free    = !result_valid_q || result_ready;
	assign run_done     = (k_q == n_q);
	assign age          = now_q - head.stamp;
	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign pready       = 1'b1;
	assign prdata       = PDATA_W'(timeout_q);

	always_comb begin
		ctl      = '0;
		put_idx  = IW'(occ_q - 1'b1);
		put_data = head;
		go       = 1'b0;
		keep     = 1'b1;
		match    = 1'b0;
		done     = 1'b0;
		emit     = 1'b0;
		rsp_d    = '0;
		unique case (state_q)
			S_RUN: begin
				if (!run_done) begin
					unique case (op_q)
						OP_LEARN: begin
							go             = 1'b1;
							match          = (head.addr == addr_q) && !hit_q;
							put_data.stamp = match ? now_q : head.stamp;
						end
						OP_SWEEP: begin
							go   = 1'b1;
							keep = (age <= TIME_W'(timeout_q));
						end
						OP_LIST: begin
							go                   = slot_free;
							emit                 = slot_free;
							rsp_d.status         = ST_LISTED;
							rsp_d.entry_index    = INDEX_W'(k_q);
							rsp_d.listed_address = head.addr;
							rsp_d.entry_count    = COUNT_W'(n_q);
							rsp_d.last           = (k_q == n_q - 1'b1);
						end
						default: go = 1'b0;
					endcase
				end
				ctl.step = go;
				ctl.put  = go && keep;
			end
			S_DONE: begin
				unique case (op_q)
					OP_LEARN: begin
						done       = slot_free;
						emit       = slot_free;
						rsp_d.last = 1'b1;
						if (hit_q) begin
							rsp_d.status      = ST_REFRESHED;
							rsp_d.entry_index = INDEX_W'(hit_idx_q);
							rsp_d.entry_count = COUNT_W'(n_q);
						end else if (n_q < FULL_COUNT) begin
							rsp_d.status      = ST_INSERTED;
							rsp_d.entry_index = INDEX_W'(n_q);
							rsp_d.entry_count = COUNT_W'(n_q + 1'b1);
							ctl.put           = slot_free;
							put_idx           = IW'(n_q);
							put_data.addr     = addr_q;
							put_data.stamp    = now_q;
						end else begin
							rsp_d.status      = ST_FULL;
							rsp_d.entry_count = COUNT_W'(n_q);
						end
					end
					OP_SWEEP: begin
						done                = slot_free;
						emit                = slot_free;
						rsp_d.status        = ST_SWEPT;
						rsp_d.removed_count = COUNT_W'(removed_q);
						rsp_d.entry_count   = COUNT_W'(occ_q);
						rsp_d.last          = 1'b1;
					end
					OP_LIST: begin
						// an empty table still gives one result
						if (n_q != '0) begin
							done = 1'b1;
						end else begin
							done         = slot_free;
							emit         = slot_free;
							rsp_d.status = ST_EMPTY;
							rsp_d.last   = 1'b1;
						end
					end
					default: done = 1'b1;
				endcase
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			timeout_q      <= TIMEOUT_RESET;
			count_q        <= '0;
			result_valid_q <= 1'b0;
			hit_q          <= 1'b0;
			k_q            <= '0;
			n_q            <= '0;
			occ_q          <= '0;
			removed_q      <= '0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_TIMEOUT) begin
				timeout_q <= pwdata[TMO_W-1:0];
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid && op_t'(item.operation) != OP_NONE) begin
						state_q   <= S_RUN;
						n_q       <= count_q;
						occ_q     <= count_q;
						k_q       <= '0;
						removed_q <= '0;
						hit_q     <= 1'b0;
					end
				end
				S_RUN: begin
					if (run_done) begin
						state_q <= S_DONE;
					end else if (go) begin
						k_q <= k_q + 1'b1;
						if (!keep) begin
							occ_q     <= occ_q - 1'b1;
							removed_q <= removed_q + 1'b1;
						end
						if (match) begin
							hit_q <= 1'b1;
						end
					end
				end
				S_DONE: begin
					if (done) begin
						state_q <= S_IDLE;
						if (op_q == OP_LEARN && !hit_q && n_q < FULL_COUNT) begin
							count_q <= n_q + 1'b1;
						end else if (op_q == OP_SWEEP) begin
							count_q <= occ_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_q   <= op_t'(item.operation);
			addr_q <= item.peer_address;
			now_q  <= item.now_seconds;
		end
		if (match && go) begin
			hit_idx_q <= IW'(k_q);
		end
		if (emit) begin
			result_q <= rsp_d;
		end
	end

endmodule
